@@ hw/rtl/lzss_stream_decompressor_defines.svh @@
// Assertion macros used by the decompressor back end.
`ifndef LZSS_STREAM_DECOMPRESSOR_DEFINES_SVH
`define LZSS_STREAM_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LZSSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LZSSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/lzssd_pkg.sv @@
// Shared constants and command type for the LZSS decompressor.
package lzssd_pkg;

  localparam int WinSize   = 4096;
  localparam int WinAw     = 12;
  localparam int Lookahead = 18;
  localparam int MinMatch  = 2;
  localparam int LenW      = 5;
  localparam int FillW     = 13;
  localparam int QDepth    = 4;
  localparam int QAw       = 2;
  localparam int QCntW     = 3;

  localparam logic [WinAw-1:0] WrPosInit    = WinAw'(WinSize - Lookahead);
  localparam logic [7:0]       FillByte     = 8'h20;
  localparam logic [15:0]      FlagMarkMask = 16'hFF00;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LIT,
    OP_COPY
  } op_e;

  // One unit of work for the back end; restart is applied before op.
  typedef struct packed {
    logic             restart;
    op_e              op;
    logic [7:0]       lit;
    logic [WinAw-1:0] pos;
    logic [LenW-1:0]  len;
  } cmd_t;

endpackage

@@ hw/rtl/lzssd_front.sv @@
// Front end: token parser that turns compressed bytes into back-end commands.
module lzssd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        byte_in_i,
  input  logic              new_stream_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              full_i,
  output logic              push_o,
  output lzssd_pkg::cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TOK  = 2'd1,
    PH_REF2 = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d, phase_cur;
  logic [15:0] flag_q, flag_d, flag_cur, flag_sh;
  logic [7:0]  pend_q, pend_d, pend_cur;
  logic [lzssd_pkg::LenW-1:0] len_raw;
  logic        accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    phase_cur = new_stream_i ? PH_IDLE : phase_q;
    flag_cur  = new_stream_i ? 16'h0 : flag_q;
    pend_cur  = new_stream_i ? 8'h0 : pend_q;
    flag_sh   = {1'b0, flag_cur[15:1]};

    len_raw = lzssd_pkg::LenW'({1'b0, byte_in_i[3:0]}) +
              lzssd_pkg::LenW'(lzssd_pkg::MinMatch + 1);

    phase_d = phase_cur;
    flag_d  = flag_cur;
    pend_d  = pend_cur;

    cmd_o.restart = new_stream_i;
    cmd_o.op      = lzssd_pkg::OP_NONE;
    cmd_o.lit     = byte_in_i;
    cmd_o.pos     = {byte_in_i[7:4], pend_cur};
    cmd_o.len     = (len_raw > lzssd_pkg::LenW'(lzssd_pkg::Lookahead)) ?
                    lzssd_pkg::LenW'(lzssd_pkg::Lookahead) : len_raw;

    if (phase_cur == PH_REF2) begin
      cmd_o.op = lzssd_pkg::OP_COPY;
      phase_d  = PH_IDLE;
    end else begin
      if (phase_cur != PH_TOK && (flag_sh & lzssd_pkg::FlagMarkMask) == 16'h0) begin
        // flags used up: this byte is a new flag byte
        flag_d  = lzssd_pkg::FlagMarkMask | {8'h0, byte_in_i};
        phase_d = PH_TOK;
      end else begin
        if (phase_cur != PH_TOK) begin
          flag_d = flag_sh;
        end
        if (flag_d[0]) begin
          cmd_o.op = lzssd_pkg::OP_LIT;
          phase_d  = PH_IDLE;
        end else begin
          pend_d  = byte_in_i;
          phase_d = PH_REF2;
        end
      end
    end

    push_o = accept && (cmd_o.restart || cmd_o.op != lzssd_pkg::OP_NONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      flag_q  <= 16'h0;
      pend_q  <= 8'h0;
    end else if (accept) begin
      phase_q <= phase_d;
      flag_q  <= flag_d;
      pend_q  <= pend_d;
    end
  end

endmodule

@@ hw/rtl/lzssd_fifo.sv @@
// Command queue between front end and back end.
module lzssd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lzssd_pkg::cmd_t data_i,
  input  logic            pop_i,
  output lzssd_pkg::cmd_t data_o,
  output logic            full_o,
  output logic            empty_o
);

  lzssd_pkg::cmd_t                mem_q [lzssd_pkg::QDepth];
  logic [lzssd_pkg::QAw-1:0]      wr_ptr_q, rd_ptr_q;
  logic [lzssd_pkg::QCntW-1:0]    cnt_q;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == lzssd_pkg::QCntW'(lzssd_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ hw/rtl/lzssd_back.sv @@
// Back end: window memory, copy engine and output register.
`include "lzss_stream_decompressor_defines.svh"

module lzssd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lzssd_pkg::cmd_t cmd_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic [7:0]      data_out_o,
  output logic            last_of_run_o,
  output logic            out_valid_o,
  input  logic            out_ready_i
);

  logic [7:0] win_mem [lzssd_pkg::WinSize];

  logic [lzssd_pkg::WinAw-1:0] wp_q, src_q, src_rel;
  logic [lzssd_pkg::FillW-1:0] fill_q;
  logic [lzssd_pkg::LenW-1:0]  cnt_q;

  // read/data stage
  logic       d_valid_q, d_lit_q, d_last_q, d_hit_q, d_ok_q;
  logic [7:0] d_byte_q, byp_q, rd_q;

  logic [7:0] out_data_q;
  logic       out_last_q, out_valid_q;

  logic       adv, busy, issue, wr_en, hit_now, ok_now;
  logic [7:0] dval;

  assign adv     = !out_valid_q || out_ready_i;
  assign busy    = (cnt_q != '0);
  assign issue   = adv && busy;
  assign wr_en   = adv && d_valid_q;
  assign pop_o   = adv && !busy && !empty_i && (!cmd_i.restart || !d_valid_q);
  assign src_rel = src_q - lzssd_pkg::WrPosInit;
  // entries written since restart run from the start position for fill_q bytes
  assign ok_now  = ({1'b0, src_rel} < fill_q);
  // read colliding with the write of this cycle takes the written byte
  assign hit_now = wr_en && (wp_q == src_q);

  always_comb begin
    if (d_lit_q) begin
      dval = d_byte_q;
    end else if (d_hit_q) begin
      dval = byp_q;
    end else if (d_ok_q) begin
      dval = rd_q;
    end else begin
      dval = lzssd_pkg::FillByte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      win_mem[wp_q] <= dval;
    end
    if (issue) begin
      rd_q <= win_mem[src_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= lzssd_pkg::WrPosInit;
      fill_q      <= '0;
      src_q       <= '0;
      cnt_q       <= '0;
      d_valid_q   <= 1'b0;
      d_lit_q     <= 1'b0;
      d_last_q    <= 1'b0;
      d_hit_q     <= 1'b0;
      d_ok_q      <= 1'b0;
      d_byte_q    <= '0;
      byp_q       <= '0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o && cmd_i.restart) begin
        wp_q   <= lzssd_pkg::WrPosInit;
        fill_q <= '0;
      end else if (wr_en) begin
        wp_q <= wp_q + 1'b1;
        if (fill_q != lzssd_pkg::FillW'(lzssd_pkg::WinSize)) begin
          fill_q <= fill_q + 1'b1;
        end
      end

      if (wr_en) begin
        out_valid_q <= 1'b1;
        out_data_q  <= dval;
        out_last_q  <= d_last_q;
      end else if (adv) begin
        out_valid_q <= 1'b0;
      end

      if (adv) begin
        if (issue) begin
          d_valid_q <= 1'b1;
          d_lit_q   <= 1'b0;
          d_last_q  <= (cnt_q == lzssd_pkg::LenW'(1));
          d_hit_q   <= hit_now;
          d_ok_q    <= ok_now;
          byp_q     <= dval;
        end else if (pop_o && cmd_i.op == lzssd_pkg::OP_LIT) begin
          d_valid_q <= 1'b1;
          d_lit_q   <= 1'b1;
          d_last_q  <= 1'b1;
          d_byte_q  <= cmd_i.lit;
        end else begin
          d_valid_q <= 1'b0;
        end
      end

      if (issue) begin
        src_q <= src_q + 1'b1;
        cnt_q <= cnt_q - 1'b1;
      end else if (pop_o && cmd_i.op == lzssd_pkg::OP_COPY) begin
        src_q <= cmd_i.pos;
        cnt_q <= cmd_i.len;
      end
    end
  end

  assign data_out_o    = out_data_q;
  assign last_of_run_o = out_last_q;
  assign out_valid_o   = out_valid_q;

  `LZSSD_ASSERT_IMP(a_fill_max, 1'b1, fill_q <= lzssd_pkg::FillW'(lzssd_pkg::WinSize),
                    "fill count beyond window size")
  `LZSSD_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= lzssd_pkg::LenW'(lzssd_pkg::Lookahead),
                    "copy count beyond lookahead")
  `LZSSD_ASSERT_IMP(a_restart_idle, pop_o && cmd_i.restart, !d_valid_q && !busy,
                    "restart taken with a byte in flight")
  `LZSSD_ASSERT_NXT(a_issue_fills, issue, d_valid_q && !d_lit_q,
                    "issued read did not reach data stage")

endmodule

@@ hw/rtl/lzss_stream_decompressor.sv @@
// Path: a literal passes the queue, the data stage and the output register; a copy also loads
// its command first. Throughput: one output byte per cycle while out_ready_i holds; a
// reference holds the copy engine for its load and one window read per byte; flag bytes and
// first reference bytes cost only the parse. One window read and one window write per cycle
// set the byte rate. Reset: all control state clears at once; the window reads as 0x20 until
// written, tracked by a fill count, so no clearing pass is needed after reset or a new stream.
module lzss_stream_decompressor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] byte_in_i,
  input  logic       new_stream_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic [7:0] data_out_o,
  output logic       last_of_run_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  lzssd_pkg::cmd_t push_cmd, head_cmd;
  logic            push, pop, full, empty;

  lzssd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_in_i    (byte_in_i),
    .new_stream_i (new_stream_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  lzssd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  lzssd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (head_cmd),
    .empty_i       (empty),
    .pop_o         (pop),
    .data_out_o    (data_out_o),
    .last_of_run_o (last_of_run_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

endmodule
